// ===== rtl/core/serial_link_frame_controller_defines.svh =====
// Assertion macros shared by the frame controller RTL.
`ifndef SERIAL_LINK_FRAME_CONTROLLER_DEFINES_SVH
`define SERIAL_LINK_FRAME_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SLFC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slfc assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SLFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slfc assertion failed");

`endif

// ===== rtl/core/slfc_pkg.sv =====
// Types, constants and helpers for the serial link frame controller.
package slfc_pkg;

	localparam int RX_RING_DEPTH = 5;
	localparam int RING_IDX_W    = $clog2(RX_RING_DEPTH);

	localparam logic [7:0] SYNC_A     = 8'hFE;
	localparam logic [7:0] SYNC_B     = 8'hFF;
	localparam logic [7:0] COUNT_WRAP = 8'd254;

	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [15:0] PERIOD_RESET  = 16'd500;
	localparam logic [15:0] TICK_MAX      = 16'hFFFF;

	// Transmit frame layout: five payload bytes, checksum, two sync bytes.
	localparam int         PAYLOAD_BYTES = 5;
	localparam int         BEAT_W        = 3;
	localparam logic [2:0] BEAT_CSUM     = 3'd5;
	localparam logic [2:0] BEAT_SYNC_A   = 3'd6;
	localparam logic [2:0] BEAT_SYNC_B   = 3'd7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_BUTTONS = 2'd1,
		OP_TICK    = 2'd2
	} opcode_t;

	typedef enum logic {
		REG_TIMEOUT     = 1'b0,
		REG_SEND_PERIOD = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic       camera_on;
		logic       mic_on;
		logic       link_lost;
		logic [5:0] led_red;
		logic [5:0] led_green;
	} status_t;

	typedef struct packed {
		logic                                is_frame;
		logic [PAYLOAD_BYTES-1:0][7:0]       payload;
		status_t                             status;
	} job_t;

	function automatic logic [7:0] bump(input logic [7:0] c);
		logic [7:0] n;
		n = c + 8'd1;
		return (n >= COUNT_WRAP) ? n - COUNT_WRAP : n;
	endfunction

	function automatic status_t make_status(input logic cam, input logic mic,
		input logic lost);
		status_t s;
		s.camera_on = cam;
		s.mic_on    = mic;
		s.link_lost = lost;
		if (lost) begin
			s.led_red   = 6'd0;
			s.led_green = 6'd0;
		end else if (cam && mic) begin
			s.led_red   = 6'd40;
			s.led_green = 6'd20;
		end else if (cam) begin
			s.led_red   = 6'd40;
			s.led_green = 6'd0;
		end else if (mic) begin
			s.led_red   = 6'd20;
			s.led_green = 6'd40;
		end else begin
			s.led_red   = 6'd0;
			s.led_green = 6'd40;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/slfc_front.sv =====
// Front end: takes input beats, updates link and button state, issues jobs.
module slfc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      opcode,
	input  logic [7:0]      data_byte,
	input  logic [4:0]      button_levels,
	input  logic            wr_en,
	input  logic            wr_index,
	input  logic [15:0]     wr_data,
	output slfc_pkg::job_t  job
);
	import slfc_pkg::*;

	logic [15:0] timeout_q, period_q;

	logic [RX_RING_DEPTH-1:0][7:0] ring_q, ring_n;
	logic [RING_IDX_W-1:0]         pos_q, pos_n;
	logic [7:0]                    prev_q, prev_n;
	logic                          cam_q, cam_n, mic_q, mic_n;
	logic                          cam_req_q, cam_req_n, mic_req_q, mic_req_n;
	logic [7:0]                    plus_q, plus_n, minus_q, minus_n, shot_q, shot_n;
	logic [4:0]                    levels_q, levels_n, rise;
	logic [15:0]                   wd_q, wd_n, send_q, send_n;
	logic                          lost_q, lost_n;
	logic                          send_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			period_q  <= PERIOD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIMEOUT:     timeout_q <= wr_data;
				REG_SEND_PERIOD: period_q  <= wr_data;
				default:         ;
			endcase
		end
	end

	always_comb begin
		ring_n    = ring_q;
		pos_n     = pos_q;
		prev_n    = prev_q;
		cam_n     = cam_q;
		mic_n     = mic_q;
		cam_req_n = cam_req_q;
		mic_req_n = mic_req_q;
		plus_n    = plus_q;
		minus_n   = minus_q;
		shot_n    = shot_q;
		levels_n  = levels_q;
		wd_n      = wd_q;
		send_n    = send_q;
		lost_n    = lost_q;
		send_now  = 1'b0;
		rise      = button_levels & ~levels_q;
		case (opcode)
			OP_BYTE: begin
				ring_n[pos_q] = data_byte;
				if (prev_q == SYNC_A && data_byte == SYNC_B) begin
					pos_n = '0;
					if ((ring_n[0] ^ ring_n[1]) == ring_n[2]) begin
						wd_n   = '0;
						lost_n = 1'b0;
						cam_n  = |ring_n[0];
						mic_n  = |ring_n[1];
					end
				end else begin
					prev_n = data_byte;
					pos_n  = (pos_q == RING_IDX_W'(RX_RING_DEPTH - 1)) ? '0
						: pos_q + RING_IDX_W'(1);
				end
			end
			OP_BUTTONS: begin
				levels_n = button_levels;
				if (rise[0]) cam_req_n = ~cam_req_q;
				if (rise[1]) mic_req_n = ~mic_req_q;
				if (rise[2]) plus_n    = bump(plus_q);
				if (rise[3]) minus_n   = bump(minus_q);
				if (rise[4]) shot_n    = bump(shot_q);
			end
			OP_TICK: begin
				wd_n   = (wd_q == TICK_MAX) ? wd_q : wd_q + 16'd1;
				send_n = (send_q == TICK_MAX) ? send_q : send_q + 16'd1;
				if (wd_n >= timeout_q) lost_n = 1'b1;
				if (send_n >= period_q) begin
					send_now = 1'b1;
					send_n   = '0;
				end
			end
			default: ;
		endcase

		job.is_frame   = send_now;
		job.payload[0] = {7'd0, cam_req_q};
		job.payload[1] = {7'd0, mic_req_q};
		job.payload[2] = plus_q;
		job.payload[3] = minus_q;
		job.payload[4] = shot_q;
		job.status     = make_status(cam_n, mic_n, lost_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q    <= '0;
			pos_q     <= '0;
			prev_q    <= '0;
			cam_q     <= 1'b0;
			mic_q     <= 1'b0;
			cam_req_q <= 1'b0;
			mic_req_q <= 1'b0;
			plus_q    <= '0;
			minus_q   <= '0;
			shot_q    <= '0;
			levels_q  <= '0;
			wd_q      <= '0;
			send_q    <= '0;
			lost_q    <= 1'b0;
		end else if (accept) begin
			ring_q    <= ring_n;
			pos_q     <= pos_n;
			prev_q    <= prev_n;
			cam_q     <= cam_n;
			mic_q     <= mic_n;
			cam_req_q <= cam_req_n;
			mic_req_q <= mic_req_n;
			plus_q    <= plus_n;
			minus_q   <= minus_n;
			shot_q    <= shot_n;
			levels_q  <= levels_n;
			wd_q      <= wd_n;
			send_q    <= send_n;
			lost_q    <= lost_n;
		end
	end

endmodule

// ===== rtl/core/slfc_queue.sv =====
// Short job queue between the front end and the result sequencer.
`include "serial_link_frame_controller_defines.svh"

module slfc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  slfc_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output slfc_pkg::job_t  head
);
	import slfc_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	`SLFC_ASSERT_IMPL(a_no_push_full, push, !full)
	`SLFC_ASSERT_IMPL(a_no_pop_empty, pop, head_valid)
	`SLFC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/core/slfc_back.sv =====
// Result sequencer: expands queued jobs into result beats behind a register.
`include "serial_link_frame_controller_defines.svh"

module slfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  slfc_pkg::job_t  head,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic            tx_valid,
	output logic [7:0]      tx_byte,
	output logic            last,
	output logic            camera_on,
	output logic            mic_on,
	output logic            link_lost,
	output logic [5:0]      led_red,
	output logic [5:0]      led_green
);
	import slfc_pkg::*;

	logic [BEAT_W-1:0] beat_q;
	logic              load, beat_last;
	logic [7:0]        beat_byte, csum;

	logic              valid_s1, tx_valid_s1, last_s1;
	logic [7:0]        byte_s1;
	status_t           status_s1;

	always_comb begin
		load      = !valid_s1 || !result_stall;
		beat_last = !head.is_frame || (beat_q == BEAT_SYNC_B);
		pop       = load && head_valid && beat_last;
		csum      = head.payload[0] ^ head.payload[1] ^ head.payload[2]
			^ head.payload[3] ^ head.payload[4];
		if (beat_q < BEAT_CSUM) begin
			beat_byte = head.payload[beat_q];
		end else begin
			case (beat_q)
				BEAT_CSUM:   beat_byte = csum;
				BEAT_SYNC_A: beat_byte = SYNC_A;
				BEAT_SYNC_B: beat_byte = SYNC_B;
				default:     beat_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= '0;
		end else if (load) begin
			valid_s1 <= head_valid;
			if (head_valid)
				beat_q <= beat_last ? '0 : beat_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			tx_valid_s1 <= head.is_frame;
			byte_s1     <= head.is_frame ? beat_byte : 8'd0;
			last_s1     <= beat_last;
			status_s1   <= head.status;
		end
	end

	assign result_valid = valid_s1;
	assign tx_valid     = tx_valid_s1;
	assign tx_byte      = byte_s1;
	assign last         = last_s1;
	assign camera_on    = status_s1.camera_on;
	assign mic_on       = status_s1.mic_on;
	assign link_lost    = status_s1.link_lost;
	assign led_red      = status_s1.led_red;
	assign led_green    = status_s1.led_green;

	`SLFC_ASSERT_IMPL(a_mid_frame, beat_q != '0, head_valid && head.is_frame)
	`SLFC_ASSERT_IMPL(a_last_sync, valid_s1 && tx_valid_s1 && last_s1, byte_s1 == SYNC_B)
	`SLFC_ASSERT_NEXT(a_idle_byte, load && head_valid && !head.is_frame,
		byte_s1 == 8'd0 && last_s1)

endmodule

// ===== rtl/core/serial_link_frame_controller.sv =====
// Top level of the serial link frame controller.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  item     | item_valid / item_stall    | opcode, data_byte, button_levels
//  result   | result_valid / result_stall| tx_valid, tx_byte, last, camera_on,
//           |                            | mic_on, link_lost, led_red, led_green
//  config   | wr_en (no wait)            | wr_index, wr_data
//
// Cycles: the front end takes one item beat per clock while the queue is not full and
// updates all state in that cycle. Each item yields one result beat, or eight for a
// transmit frame; the sequencer drives one result beat per clock unless result_stall
// holds it, so frames set the output-side rate. A four-entry job queue sits between
// the two; item_stall rises only when it is full. Accepted items pass through the queue
// into the output register. Reset: arst_n clears control state at once, not queue or
// result data; no clearing pass. Reset values: timeout 2000, send period 500 ticks.
module serial_link_frame_controller (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [4:0]  button_levels,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        camera_on,
	output logic        mic_on,
	output logic        link_lost,
	output logic [5:0]  led_red,
	output logic [5:0]  led_green,
	// register writes
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data
);
	import slfc_pkg::*;

	logic  accept, q_full, q_pop, q_head_valid;
	job_t  new_job, q_head;

	// item is taken whenever the queue has a free entry
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	slfc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.button_levels (button_levels),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.job           (new_job)
	);

	slfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (new_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// expands each job into its result beats; holds the output register
	slfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.tx_valid     (tx_valid),
		.tx_byte      (tx_byte),
		.last         (last),
		.camera_on    (camera_on),
		.mic_on       (mic_on),
		.link_lost    (link_lost),
		.led_red      (led_red),
		.led_green    (led_green)
	);

endmodule
